/* rtl/core/button_gesture_sleep_controller_defines.svh */
// ----------------------------------------------------------------------------
// button gesture sleep controller assertion macros
// concurrent check wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_SLEEP_CONTROLLER_DEFINES_SVH
`define BUTTON_GESTURE_SLEEP_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define BGSC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define BGSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BGSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BGSC_ASSERT(lbl, cond, msg)
`define BGSC_ASSERT_IMP(lbl, ante, cons, msg)
`define BGSC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/bgsc_pkg.sv */
// ----------------------------------------------------------------------------
// bgsc_pkg
// shared types, codes and constants of the button gesture sleep controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bgsc_pkg;

	localparam int unsigned CFG_W = 16;
	localparam int unsigned IDLE_W = 11;
	localparam int unsigned IDX_W = 3;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned SECS_W = 8;

	localparam logic [CFG_W-1:0] COMBO_HOLD_RST = 16'd5000;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd10000;
	localparam logic [CFG_W-1:0] SCREEN_OFF_RST = 16'd2000;
	localparam logic [CFG_W-1:0] SHORT_MIN_RST = 16'd50;
	localparam logic [CFG_W-1:0] LONG_CD_RST = 16'd5000;
	localparam logic [CFG_W-1:0] SHORT_CD_RST = 16'd3000;
	localparam logic [CFG_W-1:0] FACTORY_HOLD_RST = 16'd2000;

	localparam int unsigned MS_PER_MIN = 60 * 1000;
	localparam int unsigned IDLE_PROD_W = 27;

	// ceil-seconds: (x + 999) / 1000 via reciprocal, exact for x + 999 below 2^17
	localparam int unsigned NUM_W = 17;
	localparam int unsigned DIV_K_W = 18;
	localparam int unsigned DIV_SHIFT = 27;
	localparam logic [NUM_W-1:0] ROUND_UP = 17'd999;
	localparam logic [DIV_K_W-1:0] DIV_K = 18'd134218;
	localparam int unsigned PROD_W = NUM_W + DIV_K_W;

	localparam logic [SECS_W-1:0] NOT_SHOWN = '1;

	typedef enum logic [IDX_W-1:0] {
		REG_COMBO_HOLD   = 3'd0,
		REG_LONG_PRESS   = 3'd1,
		REG_SCREEN_OFF   = 3'd2,
		REG_SHORT_MIN    = 3'd3,
		REG_LONG_CD      = 3'd4,
		REG_SHORT_CD     = 3'd5,
		REG_FACTORY_HOLD = 3'd6,
		REG_IDLE_MIN     = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_COMBO  = 3'b010,
		MODE_ARMED  = 3'b100
	} mode_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_BL_OFF  = 3'd1,
		ACT_LIGHT   = 3'd2,
		ACT_DEEP    = 3'd3,
		ACT_REBOOT  = 3'd4,
		ACT_FACTORY = 3'd5
	} act_t;

	typedef enum logic [2:0] {
		KIND_SCREEN_OFF = 3'd0,
		KIND_LIGHT      = 3'd1,
		KIND_DEEP       = 3'd2,
		KIND_REBOOT     = 3'd3,
		KIND_FACTORY    = 3'd4
	} kind_t;

	typedef struct packed {
		logic [CFG_W-1:0]  combo_hold;
		logic [CFG_W-1:0]  long_press;
		logic [CFG_W-1:0]  screen_off;
		logic [CFG_W-1:0]  short_min;
		logic [CFG_W-1:0]  long_cd;
		logic [CFG_W-1:0]  short_cd;
		logic [CFG_W-1:0]  factory_hold;
		logic [TIME_W-1:0] idle_limit;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		act_t              pend;
		logic [TIME_W-1:0] mode_start;
		logic [SECS_W-1:0] shown_cd;
		logic [SECS_W-1:0] shown_fs;
		logic              released;
		logic              fh_active;
		logic [TIME_W-1:0] fh_start;
		logic              key_seen;
		logic [TIME_W-1:0] key_start;
		logic              key_long;
		logic              key_wake;
		logic              boot_seen;
		logic [TIME_W-1:0] boot_start;
		logic              boot_long;
		logic              boot_wake;
		logic              lit;
		logic [TIME_W-1:0] last_int;
		logic              ls_cycle;
	} state_t;

	typedef struct packed {
		act_t              action;
		logic              rotate;
		logic              toggle;
		logic              wake;
		logic              redraw;
		logic              show;
		kind_t             kind;
		logic [SECS_W-1:0] secs;
		logic              active;
		logic              lit;
	} res_t;

endpackage

`default_nettype wire

/* rtl/core/button_gesture_sleep_controller.sv */
// ----------------------------------------------------------------------------
// button_gesture_sleep_controller
// button gestures, cancellable countdowns and sleep requests, one tick a beat
//
//   channel | dir | handshake            | beat
//   tick    | in  | in_valid / in_ready  | now_ms, boot_down, key_down
//   result  | out | out_valid / out_ready| action .. backlight_on
//   config  | in  | cfg_wen              | cfg_index, cfg_wdata
//
// one tick per cycle sustained while results are taken; a result is valid once
// its tick has moved from the tick register into the result register
// the tick register feeds one pass of logic that updates the gesture state
// and loads the result register in the same cycle
// a stalled result holds the tick register; a new tick still enters when
// the held tick moves on in that cycle
// reset initialises config, valid and state registers only, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "button_gesture_sleep_controller_defines.svh"

module button_gesture_sleep_controller
	import bgsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              boot_down,
	input  logic              key_down,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        action,
	output logic              rotate_pulse,
	output logic              toggle_view_pulse,
	output logic              wake_pulse,
	output logic              redraw_pulse,
	output logic              show_countdown,
	output logic [2:0]        countdown_kind,
	output logic [SECS_W-1:0] countdown_secs,
	output logic              mode_active,
	output logic              backlight_on,
	input  logic              cfg_wen,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	cfg_t                   cfg_q;
	logic [IDLE_PROD_W-1:0] idle_prod;
	state_t                 st_q;
	state_t                 st_nxt;
	res_t                   res_nxt;
	res_t                   res_q;
	logic                   out_valid_q;
	logic                   valid_s1;
	logic [TIME_W-1:0]      now_s1;
	logic                   boot_s1;
	logic                   key_s1;
	logic                   adv;

	assign adv = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// config registers
	assign idle_prod = IDLE_PROD_W'(cfg_wdata[IDLE_W-1:0]) * IDLE_PROD_W'(MS_PER_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.combo_hold <= COMBO_HOLD_RST;
			cfg_q.long_press <= LONG_PRESS_RST;
			cfg_q.screen_off <= SCREEN_OFF_RST;
			cfg_q.short_min <= SHORT_MIN_RST;
			cfg_q.long_cd <= LONG_CD_RST;
			cfg_q.short_cd <= SHORT_CD_RST;
			cfg_q.factory_hold <= FACTORY_HOLD_RST;
			cfg_q.idle_limit <= '0;
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_index))
				REG_COMBO_HOLD:   cfg_q.combo_hold <= cfg_wdata;
				REG_LONG_PRESS:   cfg_q.long_press <= cfg_wdata;
				REG_SCREEN_OFF:   cfg_q.screen_off <= cfg_wdata;
				REG_SHORT_MIN:    cfg_q.short_min <= cfg_wdata;
				REG_LONG_CD:      cfg_q.long_cd <= cfg_wdata;
				REG_SHORT_CD:     cfg_q.short_cd <= cfg_wdata;
				REG_FACTORY_HOLD: cfg_q.factory_hold <= cfg_wdata;
				REG_IDLE_MIN:     cfg_q.idle_limit <= TIME_W'(idle_prod);
			endcase
		end
	end

	// tick register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1 <= now_ms;
			boot_s1 <= boot_down;
			key_s1 <= key_down;
		end
	end

	bgsc_step u_step (
		.st        (st_q),
		.cfg       (cfg_q),
		.now_ms    (now_s1),
		.boot_down (boot_s1),
		.key_down  (key_s1),
		.nxt       (st_nxt),
		.res       (res_nxt)
	);

	// gesture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_NORMAL, pend: ACT_NONE, shown_cd: NOT_SHOWN,
				shown_fs: NOT_SHOWN, lit: 1'b1, default: '0};
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign action = res_q.action;
	assign rotate_pulse = res_q.rotate;
	assign toggle_view_pulse = res_q.toggle;
	assign wake_pulse = res_q.wake;
	assign redraw_pulse = res_q.redraw;
	assign show_countdown = res_q.show;
	assign countdown_kind = res_q.kind;
	assign countdown_secs = res_q.secs;
	assign mode_active = res_q.active;
	assign backlight_on = res_q.lit;

	`BGSC_ASSERT(a_mode_onehot, $onehot(st_q.mode), "gesture mode not one-hot")
	`BGSC_ASSERT_IMP(a_pend_idle, st_q.mode != MODE_ARMED, st_q.pend == ACT_NONE, "pending action outside armed mode")
	`BGSC_ASSERT_IMP(a_cd_quiet, out_valid_q && !res_q.show, res_q.kind == KIND_SCREEN_OFF && res_q.secs == '0, "countdown fields set without show")
	`BGSC_ASSERT_IMP(a_redraw_alone, out_valid_q && res_q.redraw, res_q.action == ACT_NONE && res_q.active, "redraw with an action")
	`BGSC_ASSERT_NXT(a_adv_loads, adv, out_valid_q, "advanced tick left no result")

endmodule

`default_nettype wire

/* rtl/core/bgsc_step.sv */
// ----------------------------------------------------------------------------
// bgsc_step
// one tick of gesture, countdown and sleep logic: state in, next state and
// result out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgsc_step
	import bgsc_pkg::*;
(
	input  state_t            st,
	input  cfg_t              cfg,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              boot_down,
	input  logic              key_down,
	output state_t            nxt,
	output res_t              res
);

	logic              reboot_c;
	logic              fh_now;
	logic [TIME_W-1:0] fh_start_c;
	logic [TIME_W-1:0] held_c;
	logic [CFG_W-1:0]  dur_c;
	logic [TIME_W-1:0] elapsed_c;
	logic [NUM_W-1:0]  num;
	logic [PROD_W-1:0] prod;
	logic [SECS_W-1:0] secs_c;

	function automatic state_t arm_f(state_t s, act_t what, logic wait_rel,
		logic [TIME_W-1:0] t);
		state_t o;
		o = s;
		o.mode = MODE_ARMED;
		o.pend = what;
		o.mode_start = t;
		o.shown_cd = NOT_SHOWN;
		o.shown_fs = NOT_SHOWN;
		o.fh_active = 1'b0;
		o.released = !wait_rel;
		o.lit = 1'b1;
		return o;
	endfunction

	function automatic kind_t pend_kind(act_t p);
		kind_t k;
		unique case (p)
			ACT_LIGHT:  k = KIND_LIGHT;
			ACT_DEEP:   k = KIND_DEEP;
			ACT_REBOOT: k = KIND_REBOOT;
			default:    k = KIND_SCREEN_OFF;
		endcase
		return k;
	endfunction

	// remaining-time numerator and seconds, rounded up
	always_comb begin
		reboot_c = (st.pend == ACT_REBOOT);
		fh_now = reboot_c && boot_down;
		fh_start_c = st.fh_active ? st.fh_start : now_ms;
		held_c = now_ms - fh_start_c;
		dur_c = (st.pend == ACT_DEEP || reboot_c) ? cfg.long_cd : cfg.short_cd;
		elapsed_c = now_ms - st.mode_start;
		if (fh_now) begin
			num = ({1'b0, cfg.factory_hold} - {1'b0, held_c[CFG_W-1:0]}) + ROUND_UP;
		end else begin
			num = ({1'b0, dur_c} - {1'b0, elapsed_c[CFG_W-1:0]}) + ROUND_UP;
		end
	end

	assign prod = PROD_W'(num) * PROD_W'(DIV_K);
	assign secs_c = prod[DIV_SHIFT+SECS_W-1:DIV_SHIFT];

	always_comb begin
		state_t            n;
		res_t              r;
		logic              active;
		logic              any;
		logic              fired;
		logic              cancel;
		logic [TIME_W-1:0] kheld;
		logic [TIME_W-1:0] bheld;
		act_t              a;

		n = st;
		r = '0;
		r.action = ACT_NONE;
		r.kind = KIND_SCREEN_OFF;
		active = 1'b0;
		any = boot_down || key_down;
		fired = 1'b0;
		cancel = 1'b0;
		kheld = now_ms - st.key_start;
		bheld = now_ms - st.boot_start;
		a = st.pend;

		unique case (st.mode)
			MODE_COMBO: begin
				active = 1'b1;
				if (!(boot_down && key_down)) begin
					n.mode = MODE_NORMAL;
					n.key_seen = 1'b0;
					n.boot_seen = 1'b0;
				end else if (elapsed_c >= TIME_W'(cfg.combo_hold)) begin
					n = arm_f(n, ACT_DEEP, 1'b1, now_ms);
				end
			end
			MODE_ARMED: begin
				active = 1'b1;
				if (!any) begin
					n.released = 1'b1;
				end
				if (reboot_c) begin
					if (boot_down) begin
						if (!n.fh_active) begin
							n.fh_active = 1'b1;
							n.fh_start = now_ms;
						end
					end else begin
						n.fh_active = 1'b0;
					end
					if (n.fh_active && held_c >= TIME_W'(cfg.factory_hold)) begin
						r.action = ACT_FACTORY;
						n.mode = MODE_NORMAL;
						n.pend = ACT_NONE;
						n.fh_active = 1'b0;
						fired = 1'b1;
					end
				end
				cancel = reboot_c ? (key_down && n.released) : (any && n.released);
				if (!fired) begin
					if (cancel) begin
						n.mode = MODE_NORMAL;
						n.pend = ACT_NONE;
						n.key_seen = key_down;
						n.boot_seen = boot_down;
						n.key_wake = key_down;
						n.boot_wake = boot_down;
						n.key_start = now_ms;
						n.boot_start = now_ms;
						n.boot_long = 1'b1;
						n.fh_active = 1'b0;
						n.last_int = now_ms;
						r.redraw = 1'b1;
					end else if (elapsed_c >= TIME_W'(dur_c)) begin
						n.mode = MODE_NORMAL;
						n.pend = ACT_NONE;
						unique case (a)
							ACT_BL_OFF: begin
								n.lit = 1'b0;
								r.action = ACT_BL_OFF;
							end
							ACT_LIGHT: begin
								n.lit = 1'b0;
								n.ls_cycle = 1'b1;
								r.action = ACT_LIGHT;
							end
							ACT_DEEP, ACT_REBOOT: begin
								r.action = a;
							end
							default: begin
								r.action = ACT_NONE;
							end
						endcase
					end else if (reboot_c && n.fh_active) begin
						if (secs_c != st.shown_fs) begin
							r.show = 1'b1;
							r.kind = KIND_FACTORY;
							r.secs = secs_c;
							n.shown_fs = secs_c;
							n.shown_cd = NOT_SHOWN;
						end
					end else if (secs_c != st.shown_cd) begin
						r.show = 1'b1;
						r.kind = pend_kind(a);
						r.secs = secs_c;
						n.shown_cd = secs_c;
						n.shown_fs = NOT_SHOWN;
					end
				end
			end
			default: begin
				if (boot_down && key_down) begin
					active = 1'b1;
					n.mode = MODE_COMBO;
					n.mode_start = now_ms;
					n.key_seen = 1'b0;
					n.boot_seen = 1'b0;
				end
			end
		endcase

		if (!active) begin
			// key button
			if (key_down && !n.key_seen) begin
				n.key_start = now_ms;
				n.key_seen = 1'b1;
				n.key_long = 1'b0;
				n.key_wake = !n.lit;
				if (!n.lit) begin
					n.lit = 1'b1;
					n.ls_cycle = 1'b0;
					r.wake = 1'b1;
				end
				n.last_int = now_ms;
			end else if (key_down && !n.key_long && !n.key_wake &&
				kheld >= TIME_W'(cfg.long_press)) begin
				n.key_long = 1'b1;
				n = arm_f(n, ACT_REBOOT, 1'b1, now_ms);
			end else if (!key_down && n.key_seen) begin
				n.key_seen = 1'b0;
				if (!n.key_long && !n.key_wake && kheld >= TIME_W'(cfg.short_min) &&
					kheld < TIME_W'(cfg.long_press)) begin
					r.toggle = 1'b1;
				end
			end
			// boot button
			if (boot_down && !n.boot_seen) begin
				n.boot_start = now_ms;
				n.boot_seen = 1'b1;
				n.boot_long = 1'b0;
				n.boot_wake = !n.lit;
				if (!n.lit) begin
					n.lit = 1'b1;
					n.ls_cycle = 1'b0;
					r.wake = 1'b1;
				end
				n.last_int = now_ms;
			end else if (boot_down && !n.boot_long && !n.boot_wake &&
				bheld >= TIME_W'(cfg.screen_off)) begin
				n.boot_long = 1'b1;
				n = arm_f(n, ACT_BL_OFF, 1'b1, now_ms);
			end else if (!boot_down && n.boot_seen) begin
				n.boot_seen = 1'b0;
				if (!n.boot_long && !n.boot_wake && bheld >= TIME_W'(cfg.short_min) &&
					bheld < TIME_W'(cfg.screen_off)) begin
					r.rotate = 1'b1;
				end
			end
			// idle light sleep
			if (!n.lit && cfg.idle_limit != '0) begin
				if (n.ls_cycle) begin
					r.action = ACT_LIGHT;
				end else if (now_ms - n.last_int >= cfg.idle_limit) begin
					n = arm_f(n, ACT_LIGHT, 1'b0, now_ms);
				end
			end
		end

		r.active = active;
		r.lit = n.lit;
		nxt = n;
		res = r;
	end

endmodule

`default_nettype wire
